FILE: rtl/poas_pkg.sv
// shared constants, codes and control types of the octopus authentication set block
package poas_pkg;

   localparam int TREE_BITS_C   = 16;
   localparam int NUM_INDICES_C = 16;
   localparam int AUTH_MAX_C    = 32;

   localparam int NODE_W    = 16;
   localparam int LEVEL_W   = 4;
   localparam int LEAF_W    = TREE_BITS_C + 1;
   localparam int LVL_CNT_W = $clog2(TREE_BITS_C);

   localparam logic [LEAF_W-1:0] LEAF_LO = LEAF_W'(1) << (TREE_BITS_C - 1);
   localparam logic [LEAF_W-1:0] LEAF_HI = LEAF_W'(1) << TREE_BITS_C;

   typedef enum logic [1:0] {
      RSP_OK       = 2'd0,
      RSP_OVERFLOW = 2'd1,
      RSP_EMPTY    = 2'd2,
      RSP_BAD      = 2'd3
   } rsp_status_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_SCAN,
      OP_WALK,
      OP_APPEND,
      OP_OUT
   } rd_op_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SCAN_W,
      ST_CHECK,
      ST_WALK,
      ST_WALK_W,
      ST_FLUSH,
      ST_APPEND,
      ST_APPEND_W,
      ST_LEVEL,
      ST_SINGLE,
      ST_OUT,
      ST_OUT_W
   } state_type;

   typedef struct packed {
      logic      load;
      logic      start_scan;
      logic      init_build;
      logic      rewind;
      logic      flush;
      logic      level_end;
      logic      single;
      logic      clear;
      rd_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic last_in;
      logic rd_done;
      logic bad;
      logic tree_done;
      logic no_list;
   } dp_status_type;

endpackage

FILE: rtl/poas_ram.sv
// generic one write port, one read port ram with registered read data
module poas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/poas_ctrl.sv
// sequencer for loading, scanning, level walks and result output
module poas_ctrl import poas_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd,
   output logic          busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (start && dp_status.last_in) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (dp_status.rd_done) state_in = ST_SCAN_W;
         end
         ST_SCAN_W: state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = dp_status.bad ? ST_SINGLE : ST_WALK;
         end
         ST_WALK: begin
            if (dp_status.rd_done) state_in = ST_WALK_W;
         end
         ST_WALK_W: state_in = ST_FLUSH;
         ST_FLUSH:  state_in = ST_APPEND;
         ST_APPEND: begin
            if (dp_status.rd_done) state_in = ST_APPEND_W;
         end
         ST_APPEND_W: state_in = ST_LEVEL;
         ST_LEVEL: begin
            if (!dp_status.tree_done) state_in = ST_WALK;
            else if (dp_status.no_list) state_in = ST_SINGLE;
            else state_in = ST_OUT;
         end
         ST_SINGLE: state_in = ST_LOAD;
         ST_OUT: begin
            if (dp_status.rd_done) state_in = ST_OUT_W;
         end
         ST_OUT_W: state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      dp_cmd = '0;
      dp_cmd.op = OP_IDLE;
      busy = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            busy = 1'b0;
            dp_cmd.load = start;
            dp_cmd.start_scan = start && dp_status.last_in;
         end
         ST_SCAN:   dp_cmd.op = OP_SCAN;
         ST_CHECK:  dp_cmd.init_build = 1'b1;
         ST_WALK:   dp_cmd.op = OP_WALK;
         ST_FLUSH:  dp_cmd.flush = 1'b1;
         ST_APPEND: dp_cmd.op = OP_APPEND;
         ST_LEVEL: begin
            dp_cmd.level_end = 1'b1;
            dp_cmd.rewind = 1'b1;
         end
         ST_SINGLE: begin
            dp_cmd.single = 1'b1;
            dp_cmd.clear = 1'b1;
         end
         ST_OUT:   dp_cmd.op = OP_OUT;
         ST_OUT_W: dp_cmd.clear = 1'b1;
         default: begin
            dp_cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/poas_dp.sv
// node lists, sibling walk, entry buffer and result register
module poas_dp import poas_pkg::*; #(
   parameter int NUM_INDICES = NUM_INDICES_C,
   parameter int AUTH_MAX    = AUTH_MAX_C
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [NODE_W-1:0]   req_index_value,
   input  logic                csr_wr_en,
   input  logic [LEAF_W-1:0]   csr_wr_data,
   input  dp_cmd_type          dp_cmd,
   output dp_status_type       dp_status,
   output logic                rsp_strobe,
   output logic [LEVEL_W-1:0]  rsp_node_level,
   output logic [NODE_W-1:0]   rsp_node_index,
   output logic [1:0]          rsp_status,
   output logic                rsp_last_item
);

   localparam int ADDR_W  = $clog2(NUM_INDICES);
   localparam int CNT_W   = $clog2(NUM_INDICES + 1);
   localparam int AUTH_AW = (AUTH_MAX > 1) ? $clog2(AUTH_MAX) : 1;
   localparam int AUTH_CW = $clog2(AUTH_MAX + 1);
   localparam int RC_W    = (CNT_W > AUTH_CW) ? CNT_W : AUTH_CW;
   localparam int AUTH_DW = LEVEL_W + NODE_W;

   logic [LEAF_W-1:0]    leaf_count_ff;
   logic [CNT_W-1:0]     in_cnt_ff;
   logic [NODE_W-1:0]    prev_ff;
   logic                 bad_ff;
   logic [CNT_W-1:0]     n_ff;
   logic [CNT_W-1:0]     len_ff;
   logic [CNT_W-1:0]     wr_cnt_ff;
   logic [NODE_W-1:0]    first_ff;
   logic [RC_W-1:0]      rd_cnt_ff;
   logic                 rd_vld_ff;
   rd_op_type            rd_kind_ff;
   logic                 hold_vld_ff;
   logic                 hold_vld_in;
   logic [NODE_W-1:0]    hold_ff;
   logic [NODE_W-1:0]    hold_in;
   logic [AUTH_CW-1:0]   auth_cnt_ff;
   logic                 ovf_ff;
   logic [LVL_CNT_W-1:0] lvl_ff;
   logic                 sel_ff;

   logic                 rsp_strobe_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;
   logic [NODE_W-1:0]    rsp_index_ff;
   logic [1:0]           rsp_status_ff;
   logic                 rsp_last_ff;

   logic [LEAF_W-1:0]    leaf_clamp;
   logic [LEAF_W-1:0]    split;
   logic [LEAF_W-1:0]    split2;
   logic [RC_W-1:0]      rd_bound;
   logic                 rd_done;
   logic                 issue;
   logic [NODE_W-1:0]    q0;
   logic [NODE_W-1:0]    q1;
   logic [NODE_W-1:0]    q;
   logic [AUTH_DW-1:0]   auth_q;
   logic                 walk_data;
   logic                 append_data;
   logic                 scan_data;
   logic                 out_data;
   logic                 emit;
   logic [NODE_W-1:0]    emit_node;
   logic                 wr_en;
   logic [NODE_W-1:0]    wr_data;
   logic                 auth_we;
   logic                 node0_we;
   logic [ADDR_W-1:0]    node0_wa;
   logic [NODE_W-1:0]    node0_wd;

   // effective leaf count and split point of the unbalanced tree
   always_comb begin
      if (leaf_count_ff < LEAF_LO) leaf_clamp = LEAF_LO;
      else if (leaf_count_ff > LEAF_HI) leaf_clamp = LEAF_HI;
      else leaf_clamp = leaf_count_ff;
      split  = leaf_clamp - LEAF_LO;
      split2 = {split[LEAF_W-2:0], 1'b0};
   end

   always_comb begin
      case (dp_cmd.op)
         OP_SCAN:   rd_bound = RC_W'(NUM_INDICES);
         OP_WALK:   rd_bound = (lvl_ff == '0) ? RC_W'(n_ff) : RC_W'(len_ff);
         OP_APPEND: rd_bound = (lvl_ff == '0) ? RC_W'(NUM_INDICES) : rd_cnt_ff;
         OP_OUT:    rd_bound = RC_W'(auth_cnt_ff);
         default:   rd_bound = rd_cnt_ff;
      endcase
      rd_done = (rd_cnt_ff == rd_bound);
      issue   = (dp_cmd.op != OP_IDLE) && !rd_done;
   end

   assign q           = sel_ff ? q1 : q0;
   assign walk_data   = rd_vld_ff && (rd_kind_ff == OP_WALK);
   assign append_data = rd_vld_ff && (rd_kind_ff == OP_APPEND);
   assign scan_data   = rd_vld_ff && (rd_kind_ff == OP_SCAN);
   assign out_data    = rd_vld_ff && (rd_kind_ff == OP_OUT);

   // sibling pairing over the sorted node stream
   always_comb begin
      hold_vld_in = hold_vld_ff;
      hold_in     = hold_ff;
      emit        = 1'b0;
      emit_node   = hold_ff ^ NODE_W'(1);
      wr_en       = 1'b0;
      wr_data     = hold_ff >> 1;
      if (walk_data) begin
         if (hold_vld_ff) begin
            wr_en = 1'b1;
            if (q == (hold_ff ^ NODE_W'(1))) begin
               hold_vld_in = 1'b0;
            end else begin
               emit    = 1'b1;
               hold_in = q;
            end
         end else begin
            hold_in     = q;
            hold_vld_in = 1'b1;
         end
      end else if (append_data) begin
         wr_en   = 1'b1;
         wr_data = q - split[NODE_W-1:0];
      end else if (dp_cmd.flush && hold_vld_ff) begin
         emit        = 1'b1;
         wr_en       = 1'b1;
         hold_vld_in = 1'b0;
      end
      if (dp_cmd.init_build) hold_vld_in = 1'b0;
   end

   assign auth_we  = emit && (auth_cnt_ff != AUTH_CW'(AUTH_MAX));
   assign node0_we = dp_cmd.load || (wr_en && sel_ff);
   assign node0_wa = dp_cmd.load ? in_cnt_ff[ADDR_W-1:0] : wr_cnt_ff[ADDR_W-1:0];
   assign node0_wd = dp_cmd.load ? req_index_value : wr_data;

   poas_ram #(.WIDTH(NODE_W), .DEPTH(NUM_INDICES)) u_node0 (
      .clock   (clock),
      .wr_en   (node0_we),
      .wr_addr (node0_wa),
      .wr_data (node0_wd),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (q0)
   );

   poas_ram #(.WIDTH(NODE_W), .DEPTH(NUM_INDICES)) u_node1 (
      .clock   (clock),
      .wr_en   (wr_en && !sel_ff),
      .wr_addr (wr_cnt_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (q1)
   );

   poas_ram #(.WIDTH(AUTH_DW), .DEPTH(AUTH_MAX)) u_auth (
      .clock   (clock),
      .wr_en   (auth_we),
      .wr_addr (auth_cnt_ff[AUTH_AW-1:0]),
      .wr_data ({lvl_ff[LEVEL_W-1:0], emit_node}),
      .rd_addr (rd_cnt_ff[AUTH_AW-1:0]),
      .rd_data (auth_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= LEAF_HI;
         in_cnt_ff     <= '0;
         prev_ff       <= '0;
         bad_ff        <= 1'b0;
         n_ff          <= '0;
         len_ff        <= '0;
         wr_cnt_ff     <= '0;
         rd_cnt_ff     <= '0;
         rd_vld_ff     <= 1'b0;
         rd_kind_ff    <= OP_IDLE;
         hold_vld_ff   <= 1'b0;
         auth_cnt_ff   <= '0;
         ovf_ff        <= 1'b0;
         lvl_ff        <= '0;
         sel_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_wr_en) leaf_count_ff <= csr_wr_data;

         if (dp_cmd.load) begin
            in_cnt_ff <= in_cnt_ff + CNT_W'(1);
            prev_ff   <= req_index_value;
            if (in_cnt_ff != '0 && req_index_value <= prev_ff) bad_ff <= 1'b1;
         end

         if (issue) rd_cnt_ff <= rd_cnt_ff + RC_W'(1);
         rd_vld_ff  <= issue;
         rd_kind_ff <= dp_cmd.op;

         if (scan_data) begin
            if ({1'b0, q} >= leaf_clamp) bad_ff <= 1'b1;
            if ({1'b0, q} < split2) n_ff <= n_ff + CNT_W'(1);
         end

         hold_vld_ff <= hold_vld_in;

         if (wr_en) wr_cnt_ff <= wr_cnt_ff + CNT_W'(1);
         if (emit) begin
            if (auth_we) auth_cnt_ff <= auth_cnt_ff + AUTH_CW'(1);
            else ovf_ff <= 1'b1;
         end

         if (dp_cmd.start_scan) begin
            n_ff      <= '0;
            rd_cnt_ff <= '0;
         end
         if (dp_cmd.rewind) rd_cnt_ff <= '0;
         if (dp_cmd.init_build) begin
            lvl_ff      <= '0;
            sel_ff      <= 1'b0;
            auth_cnt_ff <= '0;
            ovf_ff      <= 1'b0;
            wr_cnt_ff   <= '0;
            rd_cnt_ff   <= '0;
         end
         if (dp_cmd.level_end) begin
            lvl_ff    <= lvl_ff + LVL_CNT_W'(1);
            sel_ff    <= ~sel_ff;
            len_ff    <= wr_cnt_ff;
            wr_cnt_ff <= '0;
         end
         if (dp_cmd.clear) begin
            in_cnt_ff <= '0;
            bad_ff    <= 1'b0;
            sel_ff    <= 1'b0;
         end

         rsp_strobe_ff <= dp_cmd.single || out_data;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (wr_en && wr_cnt_ff == '0) first_ff <= wr_data;
      if (dp_cmd.single) begin
         rsp_level_ff  <= '0;
         rsp_index_ff  <= '0;
         rsp_last_ff   <= 1'b1;
         if (bad_ff) rsp_status_ff <= RSP_BAD;
         else if (ovf_ff) rsp_status_ff <= RSP_OVERFLOW;
         else rsp_status_ff <= RSP_EMPTY;
      end else if (out_data) begin
         rsp_level_ff  <= auth_q[AUTH_DW-1:NODE_W];
         rsp_index_ff  <= auth_q[NODE_W-1:0];
         rsp_status_ff <= RSP_OK;
         rsp_last_ff   <= (rd_cnt_ff == RC_W'(auth_cnt_ff));
      end
   end

   always_comb begin
      dp_status.last_in   = (in_cnt_ff == CNT_W'(NUM_INDICES - 1));
      dp_status.rd_done   = rd_done;
      dp_status.bad       = bad_ff;
      dp_status.tree_done = (lvl_ff == LVL_CNT_W'(TREE_BITS_C - 1)) ||
                            (wr_cnt_ff == CNT_W'(1) && first_ff == '0);
      dp_status.no_list   = bad_ff || ovf_ff || (auth_cnt_ff == '0);
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_node_level = rsp_level_ff;
   assign rsp_node_index = rsp_index_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last_item  = rsp_last_ff;

endmodule

FILE: rtl/pors_octopus_auth_set.sv
// top level of the octopus authentication set block
// A set of NUM_INDICES ascending leaf indices is loaded one word per cycle while busy is low.
// The word that completes a set starts the build: a range scan over the stored indices,
// then one walk per tree level over the stored node list (at most 16 levels), each read
// through the single read port of the node list memories, then one result word per cycle
// for each entry; a failed or empty set gives a single word. Results
// appear for one cycle each on rsp_strobe and the receiver cannot stall them.
module pors_octopus_auth_set import poas_pkg::*; #(
   parameter int NUM_INDICES = NUM_INDICES_C,
   parameter int AUTH_MAX    = AUTH_MAX_C
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [NODE_W-1:0]  req_index_value,
   output logic               rsp_strobe,
   output logic [LEVEL_W-1:0] rsp_node_level,
   output logic [NODE_W-1:0]  rsp_node_index,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_item,
   input  logic               csr_wr_en,
   input  logic [LEAF_W-1:0]  csr_wr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   poas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy)
   );

   poas_dp #(.NUM_INDICES(NUM_INDICES), .AUTH_MAX(AUTH_MAX)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_index_value (req_index_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .rsp_strobe      (rsp_strobe),
      .rsp_node_level  (rsp_node_level),
      .rsp_node_index  (rsp_node_index),
      .rsp_status      (rsp_status),
      .rsp_last_item   (rsp_last_item)
   );

endmodule

FILE: rtl/poas_chk.sv
// port level checks of the octopus authentication set block
module poas_chk import poas_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [LEVEL_W-1:0] rsp_node_level,
   input logic [NODE_W-1:0]  rsp_node_index,
   input logic [1:0]         rsp_status,
   input logic               rsp_last_item
);

   // a failure or empty word closes the set
   a_code_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != RSP_OK |-> rsp_last_item)
      else $error("status word without last_item");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != RSP_OK |-> rsp_node_level == '0 && rsp_node_index == '0)
      else $error("status word with nonzero node");

   // entry words of one set come back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_item |=> rsp_strobe)
      else $error("gap inside entry burst");

   // the final word shows either in the cycle busy drops or in the one before
   a_done: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |->
         (rsp_strobe && rsp_last_item) || $past(rsp_strobe && rsp_last_item))
      else $error("busy dropped without final word");

endmodule

bind pors_octopus_auth_set poas_chk u_poas_chk (.*);
